// ===== hdl/mhbs_pkg.sv =====
// package for the minhash band signature unit
// shared constants and opcodes; no dependencies
package mhbs_pkg;
    localparam logic [63:0] GOLDEN_C   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001B3;
    localparam logic [63:0] MIX_M1     = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_M2     = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] SEED_XOR   = 64'h00000000A5A5A5A5;
    localparam logic [63:0] FNV_BASIS  = 64'hCBF29CE484222325;
    localparam logic [31:0] ALL_ONES32 = 32'hFFFFFFFF;
    localparam int          MIX_SHIFT  = 33;
    localparam int          ROT_LEFT   = 7;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;
endpackage

// ===== hdl/mhbs_ram.sv =====
// generic single-port-write, one-read ram with registered read
// no dependencies
module mhbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/mhbs_mul64.sv =====
// iterative 64x64 low-half multiplier using one 32x32 multiplier
// no dependencies
module mhbs_mul64 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);
    // 64x64 low product built from three 32x32 partial products
    typedef enum logic [1:0] {MP_LL, MP_LH, MP_HL, MP_DONE} mul_phase_t;

    mul_phase_t  phase_reg;
    logic        busy_reg;
    logic [63:0] a_reg, b_reg, acc_reg;
    logic [31:0] mx, my;
    logic [63:0] pp;

    always_comb begin
        unique case (phase_reg)
            MP_LL:   begin mx = a_reg[31:0];  my = b_reg[31:0];  end
            MP_LH:   begin mx = a_reg[31:0];  my = b_reg[63:32]; end
            MP_HL:   begin mx = a_reg[63:32]; my = b_reg[31:0];  end
            default: begin mx = '0;           my = '0;           end
        endcase
        pp = mx * my;
    end

    assign done    = busy_reg && (phase_reg == MP_DONE);
    assign product = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= MP_LL;
        end else if (start) begin
            busy_reg  <= 1'b1;
            phase_reg <= MP_LL;
            a_reg     <= op_a;
            b_reg     <= op_b;
            acc_reg   <= '0;
        end else if (busy_reg) begin
            unique case (phase_reg)
                MP_LL: begin
                    acc_reg   <= pp;
                    phase_reg <= MP_LH;
                end
                MP_LH: begin
                    acc_reg   <= acc_reg + {pp[31:0], 32'd0};
                    phase_reg <= MP_HL;
                end
                MP_HL: begin
                    acc_reg   <= acc_reg + {pp[31:0], 32'd0};
                    phase_reg <= MP_DONE;
                end
                default: begin
                    busy_reg  <= 1'b0;
                    phase_reg <= MP_LL;
                end
            endcase
        end
    end
endmodule

// ===== hdl/minhash_band_signature_unit.sv =====
// minhash signature unit with lsh band hashes, top level
// depends on mhbs_pkg, mhbs_ram, mhbs_mul64
//
// usage: items arrive on the s_ stream (opcode in tuser). opcode 0 pushes a
// document byte, opcode 2 loads a coefficient pair, opcode 1 ends the
// document and makes the block emit SIG_LEN signature transfers on m_.
// cfg_ writes the 64-bit hash seed while the block is idle and no output
// transfer is waiting.
// s_axis_tready is low while an item is being worked on; one item at a time.
// a byte that fills the window runs two shingle hashes through one shared
// iterative 64-bit multiplier (one multiply per byte step and two in the
// final mix) and then SIG_LEN updates of two 32x32 products, compare and
// write-back, one position after another, before it is ready again.
// a byte that does not fill the window and a coefficient load leave the
// block idle.
// end of document (with a short-document hash first if needed) emits the
// words in position order; a stalled receiver holds
// the word in the output register and the sequencer waits with the next word.
// the signature store is cleared by a pass over all SIG_LEN positions after
// reset and after each document, during which s_axis_tready stays low.
// reset restores the seed to 42 and empties the window.
module minhash_band_signature_unit #(
    parameter int SIG_LEN       = 64,
    parameter int SHINGLE_WIDTH = 5,
    parameter int ROWS_PER_BAND = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // text_byte[7:0], coeff_index[13:8], coeff_a[45:14], coeff_b[77:46], zero pad
    input  logic [79:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sig_position[5:0], sig_word[37:6], band_hash[101:38], zero pad
    output logic [103:0] m_axis_tdata,
    // band_valid
    output logic         m_axis_tuser,
    // last_word
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data
);
    import mhbs_pkg::*;

    localparam int AW = $clog2(SIG_LEN);
    localparam int WB = 8 * SHINGLE_WIDTH;
    localparam int CW = $clog2(SHINGLE_WIDTH + 1);
    localparam int KW = $clog2(SHINGLE_WIDTH + 1);
    localparam int RW = (ROWS_PER_BAND > 1) ? $clog2(ROWS_PER_BAND) : 1;
    localparam int NBANDS = SIG_LEN / ROWS_PER_BAND;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_H_INIT, S_H_XOR, S_H_MUL, S_H_MWAIT,
        S_MX_X1, S_MX_M1, S_MX_W1, S_MX_X2, S_MX_M2, S_MX_W2, S_MX_X3,
        S_U_RD, S_U_WAIT, S_U_M1, S_U_M2, S_U_CMP,
        S_E_RD, S_E_WAIT, S_E_MUL, S_E_MWAIT, S_E_OUT
    } state_t;

    state_t            state_reg;
    logic [63:0]       seed_reg;
    logic [WB-1:0]     window_reg;
    logic [CW-1:0]     seen_reg;
    logic [CW-1:0]     cnt_reg;
    logic [KW-1:0]     k_reg;
    logic              pass_reg;
    logic              end_reg;
    logic [63:0]       h_reg;
    logic [31:0]       h1_reg;
    logic [AW:0]       pos_reg;
    logic [31:0]       prod_reg;
    logic [63:0]       band_reg;
    logic [31:0]       word_reg;
    logic [RW-1:0]     row_reg;
    logic [AW-1:0]     band_idx_reg;
    logic              m_valid_reg;
    logic [103:0]      m_data_reg;
    logic              m_user_reg;
    logic              m_last_reg;

    logic              mul_start;
    logic [63:0]       mul_a, mul_b, mul_p;
    logic              mul_done;
    logic              sig_we, coef_we;
    logic [AW-1:0]     sig_waddr, coef_waddr, raddr;
    logic [31:0]       sig_wdata, sig_rdata, ca_rdata, cb_rdata;
    logic [31:0]       small_p;
    logic [31:0]       small_x, small_y;
    logic [7:0]        cur_byte;
    logic [AW-1:0]     pos_idx;
    logic [RW-1:0]     row;
    logic [AW-1:0]     band;
    logic              s_fire;
    logic              emit_fire;
    logic              band_done;

    assign pos_idx = pos_reg[AW-1:0];
    assign raddr   = pos_idx;
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE) && !m_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    assign row  = row_reg;
    assign band = band_idx_reg;
    assign emit_fire = (state_reg == S_E_OUT) && (!m_valid_reg || m_axis_tready);
    assign band_done = (32'(row) == ROWS_PER_BAND - 1) && (32'(band) < NBANDS);

    assign small_p = small_x * small_y;
    always_comb begin
        small_x = ca_rdata;
        small_y = h1_reg;
        if (state_reg == S_U_M2) begin
            small_x = cb_rdata;
            small_y = h_reg[31:0];
        end
    end

    always_comb begin
        cur_byte = '0;
        if (32'(k_reg) < 32'(cnt_reg)) begin
            cur_byte = window_reg[8 * (32'(cnt_reg) - 1 - 32'(k_reg)) +: 8];
        end
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = h_reg;
        mul_b     = FNV_PRIME;
        unique case (state_reg)
            S_H_MUL: begin
                mul_start = 1'b1;
                mul_a     = {h_reg[63-ROT_LEFT:0], h_reg[63:64-ROT_LEFT]};
            end
            S_MX_M1: begin mul_start = 1'b1; mul_b = MIX_M1; end
            S_MX_M2: begin mul_start = 1'b1; mul_b = MIX_M2; end
            S_E_MUL: begin
                mul_start = 1'b1;
                mul_a     = band_reg;
            end
            default: ;
        endcase
    end

    mhbs_mul64 u_mul (
        .aclk, .aresetn, .start(mul_start), .op_a(mul_a), .op_b(mul_b),
        .done(mul_done), .product(mul_p)
    );

    always_comb begin
        coef_we    = s_fire && (s_axis_tuser == OP_LOAD)
                     && (32'(s_axis_tdata[13:8]) < SIG_LEN);
        coef_waddr = AW'(s_axis_tdata[13:8]);
        sig_we     = 1'b0;
        sig_waddr  = pos_idx;
        sig_wdata  = ALL_ONES32;
        if (state_reg == S_CLEAR) begin
            sig_we = 1'b1;
        end else if (state_reg == S_U_CMP) begin
            sig_we    = prod_reg < sig_rdata;
            sig_wdata = prod_reg;
        end
    end

    mhbs_ram #(.WIDTH(32), .DEPTH(SIG_LEN)) u_sig (
        .aclk, .we(sig_we), .waddr(sig_waddr), .wdata(sig_wdata),
        .raddr, .rdata(sig_rdata)
    );
    mhbs_ram #(.WIDTH(32), .DEPTH(SIG_LEN)) u_ca (
        .aclk, .we(coef_we), .waddr(coef_waddr), .wdata(s_axis_tdata[45:14]),
        .raddr, .rdata(ca_rdata)
    );
    mhbs_ram #(.WIDTH(32), .DEPTH(SIG_LEN)) u_cb (
        .aclk, .we(coef_we), .waddr(coef_waddr), .wdata(s_axis_tdata[77:46]),
        .raddr, .rdata(cb_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            seed_reg    <= 64'd42;
            window_reg  <= '0;
            seen_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
            end_reg     <= 1'b0;
        end else begin
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_data;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    if (32'(pos_reg) == SIG_LEN - 1) begin
                        pos_reg   <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        pass_reg     <= 1'b0;
                        k_reg        <= '0;
                        pos_reg      <= '0;
                        row_reg      <= '0;
                        band_idx_reg <= '0;
                        if (s_axis_tuser == OP_BYTE) begin
                            window_reg <= {window_reg[WB-9:0], s_axis_tdata[7:0]};
                            cnt_reg    <= CW'(SHINGLE_WIDTH);
                            if (32'(seen_reg) < SHINGLE_WIDTH) begin
                                seen_reg <= seen_reg + 1'b1;
                            end
                            end_reg <= 1'b0;
                            if (32'(seen_reg) + 1 >= SHINGLE_WIDTH) begin
                                state_reg <= S_H_INIT;
                            end
                        end else if (s_axis_tuser == OP_END) begin
                            end_reg <= 1'b1;
                            cnt_reg <= seen_reg;
                            if (seen_reg != '0 && 32'(seen_reg) < SHINGLE_WIDTH) begin
                                state_reg <= S_H_INIT;
                            end else begin
                                state_reg <= S_E_RD;
                            end
                        end
                    end
                end
                S_H_INIT: begin
                    h_reg     <= (pass_reg ? (seed_reg ^ SEED_XOR) : seed_reg) ^ GOLDEN_C;
                    k_reg     <= '0;
                    state_reg <= S_H_XOR;
                end
                S_H_XOR: begin
                    h_reg     <= h_reg ^ {56'd0, cur_byte};
                    state_reg <= S_H_MUL;
                end
                S_H_MUL: state_reg <= S_H_MWAIT;
                S_H_MWAIT: begin
                    if (mul_done) begin
                        h_reg <= mul_p;
                        k_reg <= k_reg + 1'b1;
                        if (32'(k_reg) == SHINGLE_WIDTH - 1) begin
                            state_reg <= S_MX_X1;
                        end else begin
                            state_reg <= S_H_XOR;
                        end
                    end
                end
                S_MX_X1: begin
                    h_reg     <= h_reg ^ (h_reg >> MIX_SHIFT);
                    state_reg <= S_MX_M1;
                end
                S_MX_M1: state_reg <= S_MX_W1;
                S_MX_W1: begin
                    if (mul_done) begin
                        h_reg     <= mul_p;
                        state_reg <= S_MX_X2;
                    end
                end
                S_MX_X2: begin
                    h_reg     <= h_reg ^ (h_reg >> MIX_SHIFT);
                    state_reg <= S_MX_M2;
                end
                S_MX_M2: state_reg <= S_MX_W2;
                S_MX_W2: begin
                    if (mul_done) begin
                        h_reg     <= mul_p;
                        state_reg <= S_MX_X3;
                    end
                end
                S_MX_X3: begin
                    h_reg <= h_reg ^ (h_reg >> MIX_SHIFT);
                    if (!pass_reg) begin
                        h1_reg    <= h_reg[31:0] ^ 32'(h_reg >> MIX_SHIFT);
                        pass_reg  <= 1'b1;
                        state_reg <= S_H_INIT;
                    end else begin
                        pos_reg   <= '0;
                        state_reg <= S_U_RD;
                    end
                end
                S_U_RD:   state_reg <= S_U_WAIT;
                S_U_WAIT: state_reg <= S_U_M1;
                S_U_M1: begin
                    prod_reg  <= small_p;
                    state_reg <= S_U_M2;
                end
                S_U_M2: begin
                    prod_reg  <= prod_reg + small_p;
                    state_reg <= S_U_CMP;
                end
                S_U_CMP: begin
                    // write-back compares the completed sum held in prod_reg
                    if (32'(pos_reg) == SIG_LEN - 1) begin
                        pos_reg   <= '0;
                        state_reg <= end_reg ? S_E_RD : S_IDLE;
                    end else begin
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= S_U_RD;
                    end
                end
                S_E_RD:   state_reg <= S_E_WAIT;
                S_E_WAIT: begin
                    word_reg  <= sig_rdata;
                    band_reg  <= ((row == '0) ? (FNV_BASIS ^ 64'(band)) : band_reg)
                                 ^ {32'd0, sig_rdata};
                    state_reg <= S_E_MUL;
                end
                S_E_MUL: state_reg <= S_E_MWAIT;
                S_E_MWAIT: begin
                    if (mul_done) begin
                        band_reg  <= mul_p;
                        state_reg <= S_E_OUT;
                    end
                end
                S_E_OUT: begin
                    if (emit_fire) begin
                        m_last_reg <= (32'(pos_reg) == SIG_LEN - 1);
                        m_user_reg <= band_done;
                        m_data_reg <= {2'b00, (band_done ? band_reg : 64'd0),
                                       word_reg, 6'(pos_reg)};
                        if (32'(row) == ROWS_PER_BAND - 1) begin
                            row_reg      <= '0;
                            band_idx_reg <= band_idx_reg + 1'b1;
                        end else begin
                            row_reg <= row_reg + 1'b1;
                        end
                        if (32'(pos_reg) == SIG_LEN - 1) begin
                            pos_reg    <= '0;
                            window_reg <= '0;
                            seen_reg   <= '0;
                            state_reg  <= S_CLEAR;
                        end else begin
                            pos_reg   <= pos_reg + 1'b1;
                            state_reg <= S_E_RD;
                        end
                    end
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_axis_tready |=> m_valid_reg && $stable(m_data_reg))
        else $error("output changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_valid_reg || state_reg == S_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        coef_we |-> state_reg == S_IDLE)
        else $error("coefficient write while busy");
endmodule

// ===== tb/minhash_band_signature_unit_tb.sv =====
// self-checking testbench for minhash_band_signature_unit
// predicts signature and band hash transfers from the s_ stream and checks m_
// depends on mhbs_pkg and the unit itself
module minhash_band_signature_unit_tb;
    import mhbs_pkg::*;

    localparam int SIG_N  = 64;
    localparam int SHW    = 5;
    localparam int ROWS   = 8;
    localparam int LIMIT  = 4000000;

    typedef struct packed {
        logic        last_word;
        logic [63:0] band_hash;
        logic        band_valid;
        logic [31:0] sig_word;
        logic [5:0]  sig_position;
    } sig_out_t;

    class sig_scoreboard;
        logic [63:0] seed;
        logic [39:0] window;
        int unsigned filled;
        logic [31:0] min_sig[SIG_N];
        logic [31:0] mul_a[SIG_N];
        logic [31:0] mul_b[SIG_N];
        sig_out_t    pending[$];
        int unsigned errors;
        int unsigned words_seen;

        function new();
            seed = 64'd42;
            errors = 0;
            words_seen = 0;
            for (int i = 0; i < SIG_N; i++) begin
                mul_a[i] = '0;
                mul_b[i] = '0;
            end
            clear_doc();
        endfunction

        function void clear_doc();
            window = '0;
            filled = 0;
            for (int i = 0; i < SIG_N; i++) min_sig[i] = ALL_ONES32;
        endfunction

        function logic [63:0] shingle(logic [63:0] s, int unsigned cnt);
            logic [63:0] h;
            logic [63:0] b;
            h = s ^ GOLDEN_C;
            for (int k = 0; k < SHW; k++) begin
                b = 0;
                if (k < cnt) b = (window >> (8 * (cnt - 1 - k))) & 64'hFF;
                h ^= b;
                h = {h[56:0], h[63:57]} * FNV_PRIME;
            end
            h ^= h >> 33;
            h *= MIX_M1;
            h ^= h >> 33;
            h *= MIX_M2;
            h ^= h >> 33;
            return h;
        endfunction

        function void fold_shingle(int unsigned cnt);
            logic [31:0] h1;
            logic [31:0] h2;
            logic [31:0] v;
            h1 = 32'(shingle(seed, cnt));
            h2 = 32'(shingle(seed ^ SEED_XOR, cnt));
            for (int i = 0; i < SIG_N; i++) begin
                v = mul_a[i] * h1 + mul_b[i] * h2;
                if (v < min_sig[i]) min_sig[i] = v;
            end
        endfunction

        function void note_input(logic [1:0] op, logic [79:0] d);
            sig_out_t   r;
            logic [63:0] acc;
            if (op == OP_BYTE) begin
                window = {window[31:0], d[7:0]};
                if (filled < SHW) filled++;
                if (filled >= SHW) fold_shingle(SHW);
            end else if (op == OP_LOAD) begin
                mul_a[d[13:8]] = d[45:14];
                mul_b[d[13:8]] = d[77:46];
            end else if (op == OP_END) begin
                if (filled > 0 && filled < SHW) fold_shingle(filled);
                acc = 0;
                for (int i = 0; i < SIG_N; i++) begin
                    if (i % ROWS == 0) acc = FNV_BASIS ^ 64'(i / ROWS);
                    acc ^= 64'(min_sig[i]);
                    acc *= FNV_PRIME;
                    r.sig_position = 6'(i);
                    r.sig_word = min_sig[i];
                    r.band_valid = (i % ROWS == ROWS - 1);
                    r.band_hash = r.band_valid ? acc : 64'd0;
                    r.last_word = (i == SIG_N - 1);
                    pending = {pending, r};
                end
                clear_doc();
            end
        endfunction

        function void check_word(logic [103:0] d, logic tu, logic tl);
            sig_out_t e;
            sig_out_t a;
            a = {tl, d[101:38], tu, d[37:0]};
            words_seen++;
            if (pending.size() == 0) begin
                $error("unexpected transfer pos=%0d", a.sig_position);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.sig_position !== e.sig_position) begin
                $error("sig_position exp %0d got %0d", e.sig_position, a.sig_position);
                errors++;
            end
            if (a.sig_word !== e.sig_word) begin
                $error("sig_word exp %h got %h", e.sig_word, a.sig_word);
                errors++;
            end
            if (a.band_valid !== e.band_valid) begin
                $error("band_valid exp %0b got %0b", e.band_valid, a.band_valid);
                errors++;
            end
            if (a.band_hash !== e.band_hash) begin
                $error("band_hash exp %h got %h", e.band_hash, a.band_hash);
                errors++;
            end
            if (a.last_word !== e.last_word) begin
                $error("last_word exp %0b got %0b", e.last_word, a.last_word);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [63:0]  cfg_data = '0;

    sig_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned docs = 0;
    int unsigned stall_mode = 0;
    logic [63:0] seeds[5];

    minhash_band_signature_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall pattern: phases of always ready, random, and long stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [79:0] d);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(op, d);
        if (op == OP_END) docs++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, {72'd0, b});
    endtask

    task automatic send_load(input logic [5:0] idx, input logic [31:0] a,
                             input logic [31:0] b);
        send_item(OP_LOAD, {2'b00, b, a, idx, 8'd0});
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.seed = v;
    endtask

    task automatic random_doc();
        int unsigned len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
        for (int i = 0; i < len; i++) send_byte(8'($urandom));
        send_item(OP_END, 80'($urandom & 32'hFF));
    endtask

    initial begin
        seeds[0] = 64'd0;
        seeds[1] = 64'hFFFFFFFFFFFFFFFF;
        seeds[2] = {$urandom, $urandom};
        seeds[3] = 64'hA5A5A5A5;
        seeds[4] = {$urandom, $urandom};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty document before any load skips the shingle hashes and signature updates
        send_item(OP_END, '0);
        // load every position, with extreme values at the first two positions
        for (int i = 0; i < SIG_N; i++) begin
            if (i == 0) send_load(6'(i), 32'd0, 32'd0);
            else if (i == 1) send_load(6'(i), 32'hFFFFFFFF, 32'hFFFFFFFF);
            else send_load(6'(i), $urandom, $urandom);
        end
        send_item(OP_RSVD, 80'({$urandom, $urandom, $urandom}));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_item(OP_END, '0);
        for (int i = 0; i < 7; i++) send_byte(i[0] ? 8'hFF : 8'h00);
        send_item(OP_END, '0);

        drain();
        for (int p = 0; p < 5; p++) begin
            write_seed(seeds[p]);
            for (int d = 0; d < 4; d++) begin
                if ($urandom_range(0, 3) == 0)
                    send_load(6'($urandom), $urandom, $urandom);
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_RSVD, 80'({$urandom, $urandom, $urandom}));
                random_doc();
            end
        end
        write_seed(64'd42);
        random_doc();

        drain();
        $display("covered %0d documents, %0d signature words, 6 seed settings",
                 docs, sb.words_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== minhash_band_signature_unit.f =====
hdl/mhbs_pkg.sv
hdl/mhbs_ram.sv
hdl/mhbs_mul64.sv
hdl/minhash_band_signature_unit.sv
tb/minhash_band_signature_unit_tb.sv
